@@ sv/arrw_pkg.sv @@
// Shared constants and types for the adaptive read request window block.
package arrw_pkg;

    localparam int unsigned OFF_W      = 48;
    localparam int unsigned BSIZE_W    = 17;
    localparam int unsigned WIN_W      = 15;
    localparam int unsigned MS_W       = 32;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 72;

    // Upper bound of the request window.
    localparam logic [WIN_W-1:0] WINDOW_CAP = WIN_W'(16384);
    localparam int unsigned READS_PER_STEP_DEF = 2;

    // Round-trip target: ideal = window * 500 / elapsed_ms.
    localparam int unsigned TARGET_MS = 500;
    // Dividend window * 500 fits in WIN_W + 9 bits.
    localparam int unsigned DIVD_W    = WIN_W + 9;

    // Reset values of the configuration registers.
    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = BSIZE_W'(32768);
    localparam logic [WIN_W-1:0]   INIT_WIN_RST   = WIN_W'(128);
    localparam logic [OFF_W-1:0]   START_OFF_RST  = '0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_WIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFF  = 2'd2;

    // Input operation codes.
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_OPPTY = 1'b1;

    // Result kinds.
    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT_REP = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_MEAS  = 6'b000100,
        S_DIV   = 6'b001000,
        S_ADJ   = 6'b010000,
        S_ISSUE = 6'b100000
    } arrw_state_t;

endpackage

@@ sv/adaptive_read_request_window_core.sv @@
// Top level of the adaptive read request window: sequencer, serial divider, result register.
//
// Paces pipelined block reads for a download. Each input transaction is either a
// received data block (s_tuser = 0, carrying its size) or a bare request opportunity
// (s_tuser = 1). A good block advances the received offset; an oversized block, or a
// second short block, yields one status result and leaves the state alone. When the
// received offset reaches the offset where a round-trip measurement started, the
// elapsed time sets a target of window*500/elapsed_ms and the window moves toward it
// by a half or an eighth, clamped between initial_window and 16384. The block then
// issues up to READS_PER_STEP reads at consecutive block offsets while can_send is
// set and pending_count plus reads already issued stays below the window; if no
// read goes out, one status result is sent. Each result carries the current
// window, and m_tlast marks the final result of an input transaction. When a
// measurement completes, the restoring divider retires one quotient bit per cycle
// over the 24-bit dividend, then the window is adjusted. A result that waits for
// m_tready stalls the item. The result register lets the next input be accepted
// while the final result still waits for m_tready. Configuration writes (cfg_index 0
// block_size, 1 initial_window, 2 start_offset) are taken every cycle and must only
// occur while the block is idle; writing initial_window reloads the window and
// writing start_offset reloads both offsets.
module adaptive_read_request_window_core
    import arrw_pkg::*;
#(
    parameter int unsigned READS_PER_STEP = READS_PER_STEP_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input transactions
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // data_size[16:0], now_ms[48:17],
                                             // pending_count[63:49], can_send[64], zero pad
    input  logic                  s_tuser,   // op
    // result transactions
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // read_offset[47:0], status[49:48],
                                             // window[64:50], zero pad
    output logic                  m_tuser,   // kind
    output logic                  m_tlast,   // last
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [OFF_W-1:0]      cfg_data
);

    localparam int unsigned CNT_W  = $clog2(READS_PER_STEP + 1);
    localparam int unsigned DCNT_W = $clog2(DIVD_W);

    // ---------------- registers ----------------
    arrw_state_t            state_reg, state_next;

    logic [BSIZE_W-1:0]     block_size_reg, block_size_next;
    logic [WIN_W-1:0]       init_win_reg, init_win_next;

    logic [WIN_W-1:0]       window_limit_reg, window_limit_next;
    logic [OFF_W-1:0]       next_req_reg, next_req_next;
    logic [OFF_W-1:0]       recv_off_reg, recv_off_next;
    logic                   timing_active_reg, timing_active_next;
    logic [MS_W-1:0]        timing_start_reg, timing_start_next;
    logic [OFF_W-1:0]       timing_target_reg, timing_target_next;
    logic                   short_seen_reg, short_seen_next;

    // latched input item
    logic                   in_op_reg, in_op_next;
    logic [BSIZE_W-1:0]     in_size_reg, in_size_next;
    logic [MS_W-1:0]        in_now_reg, in_now_next;
    logic [WIN_W-1:0]       in_pend_reg, in_pend_next;
    logic                   in_send_reg, in_send_next;

    // reads issued for the current item
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    // serial divider: quo_reg holds the dividend and shifts in quotient bits
    logic [DIVD_W-1:0]      quo_reg, quo_next;
    logic [MS_W-1:0]        rem_reg, rem_next;
    logic [MS_W-1:0]        divisor_reg, divisor_next;
    logic [DCNT_W-1:0]      dcnt_reg, dcnt_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg, out_kind_next;
    logic [OFF_W-1:0]       out_off_reg, out_off_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [WIN_W-1:0]       out_win_reg, out_win_next;
    logic                   out_last_reg, out_last_next;

    // ---------------- combinational helpers ----------------
    logic                   out_free;
    logic                   in_fire;
    logic                   cfg_fire;
    logic [WIN_W-1:0]       cfg_win;
    logic [MS_W-1:0]        elapsed;
    logic [DIVD_W-1:0]      dividend;
    logic [MS_W:0]          trial;
    logic                   trial_ge;
    logic [DIVD_W:0]        ideal;
    logic [DIVD_W:0]        w_ext;
    logic [DIVD_W:0]        w2_ext;
    logic [WIN_W:0]         w16;
    logic [WIN_W:0]         grow_sum;
    logic [WIN_W:0]         shrink_diff;
    logic [WIN_W-1:0]       win_adj;
    logic [WIN_W:0]         pend_cnt;
    logic [WIN_W:0]         pend_cnt1;
    logic                   issue_ok;
    logic                   more_ok;
    logic [OFF_W-1:0]       next_req_inc;

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // saturate the initial window into [1, WINDOW_CAP]
    always_comb begin
        cfg_win = cfg_data[WIN_W-1:0];
        if (cfg_win == '0) begin
            cfg_win = WIN_W'(1);
        end else if (cfg_win > WINDOW_CAP) begin
            cfg_win = WINDOW_CAP;
        end
    end

    // elapsed time, a zero interval counts as one millisecond
    always_comb begin
        elapsed = in_now_reg - timing_start_reg;
        if (elapsed == '0) begin
            elapsed = MS_W'(1);
        end
    end

    // window * 500 as shifts: 512 - 8 - 4
    assign dividend = (DIVD_W'(window_limit_reg) << 9) - (DIVD_W'(window_limit_reg) << 3)
                    - (DIVD_W'(window_limit_reg) << 2);

    assign trial    = {rem_reg, quo_reg[DIVD_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor_reg});

    // window adjustment toward the ideal
    assign ideal  = {1'b0, quo_reg};
    assign w_ext  = (DIVD_W+1)'(window_limit_reg);
    assign w2_ext = w_ext << 1;
    assign w16    = {1'b0, window_limit_reg};

    always_comb begin
        grow_sum    = w16 + ((ideal > w2_ext) ? (w16 >> 1) : (w16 >> 3));
        shrink_diff = w16 - (((ideal << 1) < w_ext) ? (w16 >> 1) : (w16 >> 3));
        win_adj     = window_limit_reg;
        if (ideal > w_ext) begin
            win_adj = (grow_sum > {1'b0, WINDOW_CAP}) ? WINDOW_CAP : grow_sum[WIN_W-1:0];
        end else if (ideal < w_ext) begin
            win_adj = (shrink_diff < {1'b0, init_win_reg}) ? init_win_reg
                                                           : shrink_diff[WIN_W-1:0];
        end
    end

    // read issue conditions for this and the following read
    assign pend_cnt     = {1'b0, in_pend_reg} + (WIN_W+1)'(cnt_reg);
    assign pend_cnt1    = pend_cnt + (WIN_W+1)'(1);
    assign issue_ok     = (cnt_reg < CNT_W'(READS_PER_STEP)) && in_send_reg
                       && (pend_cnt < {1'b0, window_limit_reg});
    assign more_ok      = ((CNT_W+1)'(cnt_reg) + (CNT_W+1)'(1) < (CNT_W+1)'(READS_PER_STEP))
                       && in_send_reg && (pend_cnt1 < {1'b0, window_limit_reg});
    assign next_req_inc = next_req_reg + OFF_W'(block_size_reg);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next         = state_reg;
        block_size_next    = block_size_reg;
        init_win_next      = init_win_reg;
        window_limit_next  = window_limit_reg;
        next_req_next      = next_req_reg;
        recv_off_next      = recv_off_reg;
        timing_active_next = timing_active_reg;
        timing_start_next  = timing_start_reg;
        timing_target_next = timing_target_reg;
        short_seen_next    = short_seen_reg;
        in_op_next         = in_op_reg;
        in_size_next       = in_size_reg;
        in_now_next        = in_now_reg;
        in_pend_next       = in_pend_reg;
        in_send_next       = in_send_reg;
        cnt_next           = cnt_reg;
        quo_next           = quo_reg;
        rem_next           = rem_reg;
        divisor_next       = divisor_reg;
        dcnt_next          = dcnt_reg;
        out_valid_next     = out_valid_reg && !m_tready;
        out_kind_next      = out_kind_reg;
        out_off_next       = out_off_reg;
        out_status_next    = out_status_reg;
        out_win_next       = out_win_reg;
        out_last_next      = out_last_reg;

        // configuration writes must arrive only while idle; the block does not enforce this
        if (cfg_fire) begin
            case (cfg_index)
                REG_BLOCK_SIZE: begin
                    block_size_next = cfg_data[BSIZE_W-1:0];
                end
                REG_INIT_WIN: begin
                    init_win_next     = cfg_win;
                    window_limit_next = cfg_win;
                end
                REG_START_OFF: begin
                    next_req_next = cfg_data;
                    recv_off_next = cfg_data;
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    in_op_next   = s_tuser;
                    in_size_next = s_tdata[16:0];
                    in_now_next  = s_tdata[48:17];
                    in_pend_next = s_tdata[63:49];
                    in_send_next = s_tdata[64];
                    cnt_next     = '0;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (in_op_reg == OP_OPPTY) begin
                    state_next = S_MEAS;
                end else if (in_size_reg > block_size_reg
                        || (in_size_reg != block_size_reg && short_seen_reg)) begin
                    // reject the block; hold until the result register frees up
                    if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_STATUS;
                        out_off_next    = '0;
                        out_status_next = (in_size_reg > block_size_reg) ? ST_OVERSIZE
                                                                         : ST_SHORT_REP;
                        out_win_next    = window_limit_reg;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else begin
                    if (in_size_reg != block_size_reg) begin
                        short_seen_next = 1'b1;
                    end
                    recv_off_next = recv_off_reg + OFF_W'(in_size_reg);
                    state_next    = S_MEAS;
                end
            end
            S_MEAS: begin
                if (timing_active_reg && recv_off_reg == timing_target_reg) begin
                    timing_active_next = 1'b0;
                    quo_next           = dividend;
                    rem_next           = '0;
                    divisor_next       = elapsed;
                    dcnt_next          = DCNT_W'(DIVD_W - 1);
                    state_next         = S_DIV;
                end else begin
                    state_next = S_ISSUE;
                end
            end
            S_DIV: begin
                // one quotient bit per cycle
                rem_next = trial_ge ? (trial[MS_W-1:0] - divisor_reg) : trial[MS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], trial_ge};
                if (dcnt_reg == '0) begin
                    state_next = S_ADJ;
                end else begin
                    dcnt_next = dcnt_reg - DCNT_W'(1);
                end
            end
            S_ADJ: begin
                window_limit_next = win_adj;
                state_next        = S_ISSUE;
            end
            S_ISSUE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_win_next   = window_limit_reg;
                    out_status_next = ST_OK;
                    if (issue_ok) begin
                        out_kind_next = KIND_READ;
                        out_off_next  = next_req_reg;
                        out_last_next = !more_ok;
                        next_req_next = next_req_inc;
                        cnt_next      = cnt_reg + CNT_W'(1);
                        if (!more_ok) begin
                            // reads fill the window exactly: start a measurement if none is running
                            if (pend_cnt1 == {1'b0, window_limit_reg} && !timing_active_reg) begin
                                timing_active_next = 1'b1;
                                timing_start_next  = in_now_reg;
                                timing_target_next = next_req_inc;
                            end
                            state_next = S_IDLE;
                        end
                    end else begin
                        // no read possible: send status only
                        out_kind_next = KIND_STATUS;
                        out_off_next  = '0;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            block_size_reg    <= BLOCK_SIZE_RST;
            init_win_reg      <= INIT_WIN_RST;
            window_limit_reg  <= INIT_WIN_RST;
            next_req_reg      <= START_OFF_RST;
            recv_off_reg      <= START_OFF_RST;
            timing_active_reg <= 1'b0;
            timing_start_reg  <= '0;
            timing_target_reg <= '0;
            short_seen_reg    <= 1'b0;
            cnt_reg           <= '0;
            dcnt_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg         <= state_next;
            block_size_reg    <= block_size_next;
            init_win_reg      <= init_win_next;
            window_limit_reg  <= window_limit_next;
            next_req_reg      <= next_req_next;
            recv_off_reg      <= recv_off_next;
            timing_active_reg <= timing_active_next;
            timing_start_reg  <= timing_start_next;
            timing_target_reg <= timing_target_next;
            short_seen_reg    <= short_seen_next;
            cnt_reg           <= cnt_next;
            dcnt_reg          <= dcnt_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_op_reg      <= in_op_next;
        in_size_reg    <= in_size_next;
        in_now_reg     <= in_now_next;
        in_pend_reg    <= in_pend_next;
        in_send_reg    <= in_send_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        out_kind_reg   <= out_kind_next;
        out_off_reg    <= out_off_next;
        out_status_reg <= out_status_next;
        out_win_reg    <= out_win_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_DATA_W - OFF_W - STATUS_W - WIN_W){1'b0}},
                       out_win_reg, out_status_reg, out_off_reg};

`ifndef SYNTHESIS
    // window stays inside its legal range
    a_win_range: assert property (@(posedge aclk) disable iff (!aresetn)
        window_limit_reg != '0 && window_limit_reg <= WINDOW_CAP)
        else $error("window out of range");

    // window never drops below the initial window
    a_win_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        window_limit_reg >= init_win_reg)
        else $error("window below initial window");

    // never more reads than allowed for one item
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(READS_PER_STEP))
        else $error("too many reads issued");

    // a read result always carries an ok status
    a_read_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg == KIND_READ) |-> out_status_reg == ST_OK)
        else $error("read result with error status");

    // a measurement that completes always runs the divider
    a_meas_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MEAS && timing_active_reg && recv_off_reg == timing_target_reg)
        |=> state_reg == S_DIV)
        else $error("measurement end skipped divider");
`endif

endmodule

@@ tb/sv/adaptive_read_request_window_core_chk.sv @@
// Checker that predicts and compares the read request window results.
module adaptive_read_request_window_core_chk
    import arrw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [OFF_W-1:0]      cfg_data,
    output int                    errors,
    output int                    awaited,
    output logic [WIN_W-1:0]      window_now,
    output logic                  reads_outstanding,
    output int                    items_seen,
    output int                    results_seen,
    output int                    window_updates
);

    typedef struct {
        logic                kind;
        logic [OFF_W-1:0]    offset;
        logic [STATUS_W-1:0] status;
        logic [WIN_W-1:0]    window;
        logic                last;
    } req_result_t;

    req_result_t awaited_results[$];

    // Registers and predicted state.
    logic [BSIZE_W-1:0] blk_size;
    logic [WIN_W-1:0]   win_floor;
    logic [WIN_W-1:0]   win;
    logic [OFF_W-1:0]   req_off;
    logic [OFF_W-1:0]   rx_off;
    logic               rtt_busy;
    logic [MS_W-1:0]    rtt_t0;
    logic [OFF_W-1:0]   rtt_mark;
    logic               short_once;

    function automatic logic [WIN_W-1:0] sat_window(input logic [WIN_W-1:0] v);
        if (v == '0) return WIN_W'(1);
        if (v > WINDOW_CAP) return WINDOW_CAP;
        return v;
    endfunction

    function automatic req_result_t make_result(input logic kind, input logic [OFF_W-1:0] offset,
                                                input logic [STATUS_W-1:0] status,
                                                input logic last);
        req_result_t r;
        r.kind   = kind;
        r.offset = offset;
        r.status = status;
        r.window = win;
        r.last   = last;
        return r;
    endfunction

    // Move the window toward window*500/elapsed_ms by a half or an eighth.
    task automatic retune_window(input logic [MS_W-1:0] now);
        logic [MS_W-1:0]  ms;
        longint unsigned  w;
        longint unsigned  ideal;
        ms = now - rtt_t0;
        if (ms == '0) ms = MS_W'(1);
        w = 64'(win);
        ideal = w * 64'(TARGET_MS) / 64'(ms);
        if (ideal > w) begin
            w += (ideal > 2 * w) ? w / 2 : w / 8;
            if (w > 64'(WINDOW_CAP)) w = 64'(WINDOW_CAP);
        end else if (ideal < w) begin
            w -= (ideal * 2 < w) ? w / 2 : w / 8;
            if (w < 64'(win_floor)) w = 64'(win_floor);
        end
        win = w[WIN_W-1:0];
        window_updates++;
    endtask

    task automatic predict_requests(input logic op, input logic [BSIZE_W-1:0] size,
                                    input logic [MS_W-1:0] now, input logic [WIN_W-1:0] pending,
                                    input logic can_send);
        logic [OFF_W-1:0] offs[$];
        int unsigned      n;
        if (op == OP_DATA) begin
            if (size > blk_size) begin
                awaited_results.push_back(make_result(KIND_STATUS, '0, ST_OVERSIZE, 1'b1));
                return;
            end
            if (size != blk_size) begin
                if (short_once) begin
                    awaited_results.push_back(make_result(KIND_STATUS, '0, ST_SHORT_REP, 1'b1));
                    return;
                end
                short_once = 1'b1;
            end
            rx_off = rx_off + OFF_W'(size);
        end
        if (rtt_busy && rx_off == rtt_mark) begin
            rtt_busy = 1'b0;
            retune_window(now);
        end
        n = 0;
        while (n < READS_PER_STEP_DEF && 32'(pending) + n < 32'(win) && can_send) begin
            offs.push_back(req_off);
            req_off = req_off + OFF_W'(blk_size);
            n++;
        end
        // Start a measurement when the reads fill the window exactly.
        if (n > 0 && 32'(pending) + n == 32'(win) && !rtt_busy) begin
            rtt_busy = 1'b1;
            rtt_t0   = now;
            rtt_mark = req_off;
        end
        if (n == 0) begin
            awaited_results.push_back(make_result(KIND_STATUS, '0, ST_OK, 1'b1));
        end else begin
            for (int k = 0; k < offs.size(); k++) begin
                awaited_results.push_back(make_result(KIND_READ, offs[k], ST_OK,
                                                      k == offs.size() - 1));
            end
        end
    endtask

    function automatic int field_diff(input string name, input longint unsigned want,
                                      input longint unsigned got);
        if (want == got) return 0;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        return 1;
    endfunction

    task automatic check_result();
        req_result_t want;
        results_seen++;
        if (awaited_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual kind %0h offset %0h",
                     $time, m_tuser, m_tdata[47:0]);
            return;
        end
        want = awaited_results.pop_front();
        errors += field_diff("kind", 64'(want.kind), 64'(m_tuser))
                + field_diff("read_offset", 64'(want.offset), 64'(m_tdata[47:0]))
                + field_diff("status", 64'(want.status), 64'(m_tdata[49:48]))
                + field_diff("window", 64'(want.window), 64'(m_tdata[64:50]))
                + field_diff("last", 64'(want.last), 64'(m_tlast));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            blk_size       = BLOCK_SIZE_RST;
            win_floor      = INIT_WIN_RST;
            win            = INIT_WIN_RST;
            req_off        = START_OFF_RST;
            rx_off         = START_OFF_RST;
            rtt_busy       = 1'b0;
            rtt_t0         = '0;
            rtt_mark       = '0;
            short_once     = 1'b0;
            errors         = 0;
            items_seen     = 0;
            results_seen   = 0;
            window_updates = 0;
            awaited_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BLOCK_SIZE: blk_size = cfg_data[BSIZE_W-1:0];
                    REG_INIT_WIN: begin
                        win_floor = sat_window(cfg_data[WIN_W-1:0]);
                        win       = win_floor;
                    end
                    REG_START_OFF: begin
                        req_off = cfg_data;
                        rx_off  = cfg_data;
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                items_seen++;
                predict_requests(s_tuser, s_tdata[16:0], s_tdata[48:17], s_tdata[63:49],
                                 s_tdata[64]);
            end
            if (m_tvalid && m_tready) check_result();
        end
        awaited           = awaited_results.size();
        window_now        = win;
        reads_outstanding = (rx_off != req_off);
    end

endmodule

@@ tb/sv/adaptive_read_request_window_core_tb.sv @@
// Testbench top for the adaptive read request window: stimulus, idling and verdict.
module adaptive_read_request_window_core_tb;
    import arrw_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 12;
    // Longest item: check, measure, 24-bit divide, adjust, two results, plus margin.
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_OFF       = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 175;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // data_size, now_ms, pending_count, can_send
    logic                  s_tuser   = OP_DATA;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // read_offset, status, window
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_BLOCK_SIZE;
    logic [OFF_W-1:0]      cfg_data  = '0;

    int               errors;
    int               awaited;
    logic [WIN_W-1:0] window_now;
    logic             reads_outstanding;
    int               items_seen;
    int               results_seen;
    int               window_updates;

    // Stimulus knobs; idling_on and hold_asks are shared with the receiver process.
    logic               idling_on   = 1'b0;
    int                 hold_asks   = 0;
    logic [MS_W-1:0]    clock_ms    = '0;
    logic [BSIZE_W-1:0] blk_cur     = BLOCK_SIZE_RST;
    int                 settings    = 1;
    int                 quiet_cycles = 0;

    always #(HALF_PERIOD) aclk = ~aclk;

    adaptive_read_request_window_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    adaptive_read_request_window_core_chk i_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .m_tlast           (m_tlast),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .errors            (errors),
        .awaited           (awaited),
        .window_now        (window_now),
        .reads_outstanding (reads_outstanding),
        .items_seen        (items_seen),
        .results_seen      (results_seen),
        .window_updates    (window_updates)
    );

    // Watchdog: end the run when no transaction moves on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles, %0d results awaited",
                     $time, quiet_cycles, awaited);
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: ready by default, random stall bursts when idling is on,
    // and one long hold-off per request from the stimulus process.
    initial begin
        int hold_taken;
        hold_taken = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_asks != hold_taken) begin
                hold_taken = hold_asks;
                m_tready = 1'b0;
                repeat (HOLD_OFF) @(negedge aclk);
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Offer one input transaction and hold it until accepted; leave valid high so
    // back-to-back items need no re-raise.
    task automatic offer_item(input logic op, input logic [BSIZE_W-1:0] size,
                              input logic [MS_W-1:0] now, input logic [WIN_W-1:0] pending,
                              input logic can_send);
        if (idling_on && $urandom_range(0, 9) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tuser  = op;
        s_tdata  = {7'd0, can_send, pending, now, size};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFF_W-1:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Drain every awaited result, let a possible in-flight divide finish, then
    // load a fresh setting. Writing start_offset realigns both offsets.
    task automatic configure(input logic [BSIZE_W-1:0] bsize, input logic [WIN_W-1:0] iwin,
                             input logic [OFF_W-1:0] start);
        s_tvalid = 1'b0;
        while (awaited != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(REG_BLOCK_SIZE, OFF_W'(bsize));
        write_reg(REG_INIT_WIN, OFF_W'(iwin));
        write_reg(REG_START_OFF, start);
        blk_cur = bsize;
        settings++;
    endtask

    // One step of a plausible download: full blocks only while reads are
    // outstanding or size is zero, pending counts clustered around the window so
    // reads fill it and start round-trip measurements, and a slow or fast clock.
    task automatic download_step();
        logic [WIN_W-1:0]   pend;
        logic               op;
        int unsigned        w;
        w = 32'(window_now);
        clock_ms += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 20);
        case ($urandom_range(0, 9))
            0, 1:    pend = WIN_W'(w - 1);
            2:       pend = WIN_W'((w >= 2) ? w - 2 : 0);
            3, 4, 5, 6, 7: pend = WIN_W'(w);
            8:       pend = WIN_W'($urandom_range(0, w));
            default: pend = WIN_W'((w < 16384) ? w + 1 : w);
        endcase
        op = ((reads_outstanding || blk_cur == '0) && $urandom_range(0, 4) != 0)
             ? OP_DATA : OP_OPPTY;
        offer_item(op, blk_cur, clock_ms, pend, $urandom_range(0, 19) != 0);
    endtask

    // Noise: any op, oversized, short or odd sizes, wild times and pending counts.
    task automatic noise_step();
        logic [BSIZE_W-1:0] size;
        case ($urandom_range(0, 3))
            0:       size = BSIZE_W'($urandom_range(0, 65536));
            1:       size = (blk_cur < BSIZE_W'(65536)) ? blk_cur + BSIZE_W'(1)
                                                        : BSIZE_W'(65536);
            2:       size = BSIZE_W'($urandom_range(0, 32'(blk_cur)));
            default: size = BSIZE_W'(65536);
        endcase
        offer_item(1'($urandom_range(0, 1)), size,
                   $urandom_range(0, 1) ? $urandom() : clock_ms,
                   WIN_W'($urandom_range(0, 16384)), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(input int items);
        repeat (items) begin
            if ($urandom_range(0, 99) < 15) noise_step();
            else download_step();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part at reset settings (block 32768, window 128): two reads,
        // channel busy, pending at its maximum, a single read that fills the
        // window, oversized blocks, measurements that grow, shrink, keep and clamp
        // the window (one with zero elapsed time), a first short block, a repeated
        // short block and a full block after it.
        offer_item(OP_OPPTY, 17'd0,     32'd0,    15'd0,     1'b1);
        offer_item(OP_OPPTY, 17'd65536, 32'd0,    15'd0,     1'b0);
        offer_item(OP_OPPTY, 17'd0,     32'd0,    15'd16384, 1'b1);
        offer_item(OP_OPPTY, 17'd0,     32'd100,  15'd127,   1'b1);
        offer_item(OP_DATA,  17'd65536, 32'd100,  15'd200,   1'b1);
        offer_item(OP_DATA,  17'd32769, 32'd100,  15'd200,   1'b1);
        repeat (3) offer_item(OP_DATA, 17'd32768, 32'd100, 15'd200, 1'b1);
        offer_item(OP_OPPTY, 17'd0,     32'd100,  15'd190,   1'b1);
        repeat (2) offer_item(OP_DATA, 17'd32768, 32'd2000, 15'd300, 1'b1);
        offer_item(OP_OPPTY, 17'd0,     32'd2100, 15'd126,   1'b1);
        repeat (2) offer_item(OP_DATA, 17'd32768, 32'd2400, 15'd300, 1'b1);
        offer_item(OP_OPPTY, 17'd0,     32'd2400, 15'd142,   1'b1);
        repeat (2) offer_item(OP_DATA, 17'd32768, 32'd2900, 15'd300, 1'b1);
        offer_item(OP_OPPTY, 17'd0,     32'd3000, 15'd143,   1'b1);
        offer_item(OP_DATA,  17'd32768, 32'd3800, 15'd300,   1'b1);
        offer_item(OP_DATA,  17'd1,     32'd3800, 15'd300,   1'b1);
        offer_item(OP_DATA,  17'd0,     32'd3800, 15'd300,   1'b1);
        offer_item(OP_DATA,  17'd32768, 32'd3800, 15'd300,   1'b1);

        // Random part over several settings, idling on both sides.
        idling_on = 1'b1;

        // Small blocks and window; hold off the result side so the block backs up.
        configure(17'd4096, 15'd4, 48'd0);
        clock_ms = $urandom();
        hold_asks++;
        run_phase(PHASE_ITEMS);

        // Largest block, smallest window, offsets and the ms clock about to wrap.
        configure(17'd65536, 15'd1, 48'hFFFF_FFFD_0000);
        clock_ms = 32'hFFFF_FF00;
        run_phase(PHASE_ITEMS);

        // Zero block size; window register above the cap saturates.
        configure(17'd0, 15'd32767, OFF_W'({$urandom(), $urandom()}));
        run_phase(PHASE_ITEMS);

        // One-byte blocks, zero window saturates to one, start at the top offset.
        configure(17'd1, 15'd0, 48'hFFFF_FFFF_FFFF);
        run_phase(PHASE_ITEMS);

        // Window pinned at the cap.
        configure(17'd512, 15'd16384, OFF_W'({$urandom(), $urandom()}));
        run_phase(PHASE_ITEMS);

        // Last stretch with no idling on either side.
        configure(BSIZE_W'($urandom_range(1, 65536)), WIN_W'($urandom_range(2, 64)),
                  OFF_W'({$urandom(), $urandom()}));
        idling_on = 1'b0;
        run_phase(PHASE_ITEMS);

        s_tvalid = 1'b0;
        while (awaited != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Covered %0d input items and %0d results with %0d window adjustments,",
                 items_seen, results_seen, window_updates);
        $display("across %0d register settings, random stalls and one long result hold-off.",
                 settings);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
